// File: rtl/tick_driven_fcfs_process_scheduler_core_assert.svh
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Shorthand for the concurrent checks used by the scheduler checker.
// ----------------------------------------------------------------------------
`ifndef TICK_DRIVEN_FCFS_PROCESS_SCHEDULER_CORE_ASSERT_SVH
`define TICK_DRIVEN_FCFS_PROCESS_SCHEDULER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDFS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold at a later cycle than the antecedent.
`define TDFS_ASSERT_DLY2(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

// File: rtl/tdfs_pkg.sv
// ----------------------------------------------------------------------------
// Scheduler package
// Sizes, codes and shared types of the tick driven FCFS scheduler.
// ----------------------------------------------------------------------------
package tdfs_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int TIME_BITS  = 16;

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

  // Fixed field widths of the transaction ports.
  localparam int FIELD_SLOT_W = 3;
  localparam int FIELD_W      = 16;

  typedef enum logic [2:0] {
    SLOT_EMPTY    = 3'd0,
    SLOT_READY    = 3'd1,
    SLOT_RUNNING  = 3'd2,
    SLOT_BLOCKED  = 3'd3,
    SLOT_FINISHED = 3'd4
  } slot_state_t;

  typedef enum logic [1:0] {
    KIND_FINISH  = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ACK     = 2'd2
  } res_kind_t;

  typedef enum logic [1:0] {
    CS_IDLE    = 2'd0,
    CS_LOAD    = 2'd1,
    CS_SCAN    = 2'd2,
    CS_SUMMARY = 2'd3
  } ctrl_state_t;

  typedef enum logic [2:0] {
    DP_NONE    = 3'd0,
    DP_CAPTURE = 3'd1,
    DP_LOAD    = 3'd2,
    DP_SCAN    = 3'd3,
    DP_SUMMARY = 3'd4
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [SLOT_W-1:0] idx;
  } dp_cmd_t;

  // Saturate a value to the 16-bit result field.
  function automatic logic [FIELD_W-1:0] clamp16(input logic [31:0] v);
    logic [FIELD_W-1:0] r;
    r = (v > 32'h0000_FFFF) ? {FIELD_W{1'b1}} : v[FIELD_W-1:0];
    return r;
  endfunction

endpackage

// File: rtl/tdfs_ctrl.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences one transaction: capture, then a load step or a slot scan
// followed by the tick summary step.
// ----------------------------------------------------------------------------
module tdfs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_op,
  output logic              busy,
  output tdfs_pkg::dp_cmd_t cmd
);

  tdfs_pkg::ctrl_state_t             state_r, state_nxt;
  logic [tdfs_pkg::SLOT_W-1:0]       idx_r, idx_nxt;

  localparam logic [tdfs_pkg::SLOT_W-1:0] LAST_IDX =
    tdfs_pkg::SLOT_W'(tdfs_pkg::SLOT_COUNT - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdfs_pkg::CS_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd.op    = tdfs_pkg::DP_NONE;
    cmd.idx   = idx_r;
    busy      = 1'b1;
    unique case (state_r)
      tdfs_pkg::CS_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.op    = tdfs_pkg::DP_CAPTURE;
          idx_nxt   = '0;
          state_nxt = in_op ? tdfs_pkg::CS_SCAN : tdfs_pkg::CS_LOAD;
        end
      end
      tdfs_pkg::CS_LOAD: begin
        cmd.op    = tdfs_pkg::DP_LOAD;
        state_nxt = tdfs_pkg::CS_IDLE;
      end
      tdfs_pkg::CS_SCAN: begin
        cmd.op = tdfs_pkg::DP_SCAN;
        if (idx_r == LAST_IDX) begin
          state_nxt = tdfs_pkg::CS_SUMMARY;
        end else begin
          idx_nxt = idx_r + tdfs_pkg::SLOT_W'(1);
        end
      end
      tdfs_pkg::CS_SUMMARY: begin
        cmd.op    = tdfs_pkg::DP_SUMMARY;
        state_nxt = tdfs_pkg::CS_IDLE;
      end
      default: begin
        state_nxt = tdfs_pkg::CS_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/tdfs_datapath.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Slot table, timers and counters, and the registered result stage.
// ----------------------------------------------------------------------------
module tdfs_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tdfs_pkg::dp_cmd_t     cmd,
  input  logic                  in_op,
  input  logic [2:0]            in_slot,
  input  logic [15:0]           in_cpu_burst,
  input  logic [15:0]           in_io_burst,
  input  logic [15:0]           in_arrival_time,
  output logic                  out_valid,
  output logic [1:0]            out_kind,
  output logic [2:0]            out_finished_slot,
  output logic [15:0]           out_turnaround,
  output logic [15:0]           out_current_time,
  output logic [2:0]            out_running_slot,
  output logic                  out_running_valid,
  output logic [15:0]           out_busy_ticks,
  output logic [15:0]           out_idle_ticks,
  output logic                  out_all_done,
  output logic                  out_last
);

  localparam int SN = tdfs_pkg::SLOT_COUNT;
  localparam int SW = tdfs_pkg::SLOT_W;
  localparam int CW = tdfs_pkg::CNT_W;
  localparam int TW = tdfs_pkg::TIME_BITS;
  localparam int FW = tdfs_pkg::FIELD_W;
  localparam int FS = tdfs_pkg::FIELD_SLOT_W;
  localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};

  // Slot table.
  tdfs_pkg::slot_state_t status_r [SN];
  tdfs_pkg::slot_state_t status_nxt [SN];
  logic [FW-1:0] cpu_left_r [SN];
  logic [FW-1:0] cpu_left_nxt [SN];
  logic [FW-1:0] io_left_r [SN];
  logic [FW-1:0] io_left_nxt [SN];
  logic [FW-1:0] arrival_r [SN];
  logic [FW-1:0] arrival_nxt [SN];

  // Scalar state.
  logic [TW-1:0] tick_r, tick_nxt;
  logic [TW-1:0] busy_cnt_r, busy_cnt_nxt;
  logic [TW-1:0] idle_cnt_r, idle_cnt_nxt;
  logic [SW-1:0] owner_r, owner_nxt;
  logic          owner_vld_r, owner_vld_nxt;
  logic [CW-1:0] fin_cnt_r, fin_cnt_nxt;
  logic [CW-1:0] load_cnt_r, load_cnt_nxt;

  // Captured transaction.
  logic [FS-1:0] cap_slot_r, cap_slot_nxt;
  logic [FW-1:0] cap_cpu_r, cap_cpu_nxt;
  logic [FW-1:0] cap_io_r, cap_io_nxt;
  logic [FW-1:0] cap_arr_r, cap_arr_nxt;

  // Result stage.
  logic                res_vld_r, res_vld_nxt;
  tdfs_pkg::res_kind_t res_kind_r, res_kind_nxt;
  logic [FS-1:0]       res_fslot_r, res_fslot_nxt;
  logic [FW-1:0]       res_ta_r, res_ta_nxt;
  logic [FW-1:0]       res_now_r, res_now_nxt;
  logic [FS-1:0]       res_rslot_r, res_rslot_nxt;
  logic                res_rvld_r, res_rvld_nxt;
  logic [FW-1:0]       res_busy_r, res_busy_nxt;
  logic [FW-1:0]       res_idle_r, res_idle_nxt;
  logic                res_done_r, res_done_nxt;
  logic                res_last_r, res_last_nxt;

  // Shared combinational terms.
  logic [SW-1:0] load_idx;
  logic          load_ok;
  logic [FW-1:0] io_cur, io_dec;
  logic [31:0]   ta_wide;
  logic [FW-1:0] now16;
  logic          ready_found;
  logic [SW-1:0] ready_first;
  logic [SW-1:0] run_idx;
  logic          run_any;
  logic [FW-1:0] cpu_cur, cpu_dec;
  logic [CW-1:0] fin_inc;

  assign load_idx = SW'(cap_slot_r);
  assign load_ok  = (cap_cpu_r != '0) && (cap_io_r != '0) && (32'(cap_slot_r) < SN) &&
                    ((status_r[load_idx] == tdfs_pkg::SLOT_EMPTY) ||
                     (status_r[load_idx] == tdfs_pkg::SLOT_FINISHED));

  assign io_cur  = io_left_r[cmd.idx];
  assign io_dec  = (io_cur != '0) ? io_cur - FW'(1) : '0;
  assign ta_wide = (32'(tick_r) >= 32'(arrival_r[cmd.idx])) ?
                   32'(tick_r) - 32'(arrival_r[cmd.idx]) : 32'd0;
  assign now16   = tdfs_pkg::clamp16(32'(tick_r));
  assign fin_inc = fin_cnt_r + CW'(1);

  // Lowest-numbered ready slot.
  always_comb begin
    ready_found = 1'b0;
    ready_first = '0;
    for (int i = 0; i < SN; i++) begin
      if (!ready_found && (status_r[i] == tdfs_pkg::SLOT_READY)) begin
        ready_found = 1'b1;
        ready_first = SW'(i);
      end
    end
  end

  assign run_idx = owner_vld_r ? owner_r : ready_first;
  assign run_any = owner_vld_r | ready_found;
  assign cpu_cur = cpu_left_r[run_idx];
  assign cpu_dec = (cpu_cur != '0) ? cpu_cur - FW'(1) : '0;

  always_comb begin
    status_nxt    = status_r;
    cpu_left_nxt  = cpu_left_r;
    io_left_nxt   = io_left_r;
    arrival_nxt   = arrival_r;
    tick_nxt      = tick_r;
    busy_cnt_nxt  = busy_cnt_r;
    idle_cnt_nxt  = idle_cnt_r;
    owner_nxt     = owner_r;
    owner_vld_nxt = owner_vld_r;
    fin_cnt_nxt   = fin_cnt_r;
    load_cnt_nxt  = load_cnt_r;
    cap_slot_nxt  = cap_slot_r;
    cap_cpu_nxt   = cap_cpu_r;
    cap_io_nxt    = cap_io_r;
    cap_arr_nxt   = cap_arr_r;
    res_vld_nxt   = 1'b0;
    res_kind_nxt  = res_kind_r;
    res_fslot_nxt = res_fslot_r;
    res_ta_nxt    = res_ta_r;
    res_now_nxt   = res_now_r;
    res_rslot_nxt = res_rslot_r;
    res_rvld_nxt  = res_rvld_r;
    res_busy_nxt  = res_busy_r;
    res_idle_nxt  = res_idle_r;
    res_done_nxt  = res_done_r;
    res_last_nxt  = res_last_r;
    unique case (cmd.op)
      tdfs_pkg::DP_NONE: begin
      end
      tdfs_pkg::DP_CAPTURE: begin
        // The operation itself is tracked by the controller.
        cap_slot_nxt = in_op ? cap_slot_r : in_slot;
        cap_cpu_nxt  = in_cpu_burst;
        cap_io_nxt   = in_io_burst;
        cap_arr_nxt  = in_arrival_time;
      end
      tdfs_pkg::DP_LOAD: begin
        if (load_ok) begin
          if (status_r[load_idx] == tdfs_pkg::SLOT_EMPTY) begin
            load_cnt_nxt = load_cnt_r + CW'(1);
          end else begin
            fin_cnt_nxt = fin_cnt_r - CW'(1);
          end
          status_nxt[load_idx]   = tdfs_pkg::SLOT_READY;
          cpu_left_nxt[load_idx] = cap_cpu_r;
          io_left_nxt[load_idx]  = cap_io_r;
          arrival_nxt[load_idx]  = cap_arr_r;
        end
        res_vld_nxt   = 1'b1;
        res_kind_nxt  = tdfs_pkg::KIND_ACK;
        res_fslot_nxt = cap_slot_r;
        res_ta_nxt    = FW'(load_ok);
        res_now_nxt   = now16;
        res_rslot_nxt = owner_vld_r ? FS'(owner_r) : '0;
        res_rvld_nxt  = owner_vld_r;
        res_busy_nxt  = tdfs_pkg::clamp16(32'(busy_cnt_r));
        res_idle_nxt  = tdfs_pkg::clamp16(32'(idle_cnt_r));
        res_done_nxt  = (fin_cnt_nxt == load_cnt_nxt);
        res_last_nxt  = 1'b1;
      end
      tdfs_pkg::DP_SCAN: begin
        if (status_r[cmd.idx] == tdfs_pkg::SLOT_BLOCKED) begin
          io_left_nxt[cmd.idx] = io_dec;
          if (io_dec == '0) begin
            status_nxt[cmd.idx] = tdfs_pkg::SLOT_FINISHED;
            fin_cnt_nxt         = fin_inc;
            res_vld_nxt         = 1'b1;
            res_kind_nxt        = tdfs_pkg::KIND_FINISH;
            res_fslot_nxt       = FS'(cmd.idx);
            res_ta_nxt          = tdfs_pkg::clamp16(ta_wide);
            res_now_nxt         = now16;
            res_rslot_nxt       = '0;
            res_rvld_nxt        = 1'b0;
            res_busy_nxt        = tdfs_pkg::clamp16(32'(busy_cnt_r));
            res_idle_nxt        = tdfs_pkg::clamp16(32'(idle_cnt_r));
            res_done_nxt        = (fin_inc == load_cnt_r);
            res_last_nxt        = 1'b0;
          end
        end
      end
      tdfs_pkg::DP_SUMMARY: begin
        if (run_any) begin
          busy_cnt_nxt          = (busy_cnt_r == TIME_MAX) ? busy_cnt_r : busy_cnt_r + TW'(1);
          cpu_left_nxt[run_idx] = cpu_dec;
          if (cpu_dec == '0) begin
            status_nxt[run_idx] = tdfs_pkg::SLOT_BLOCKED;
            owner_vld_nxt       = 1'b0;
          end else begin
            status_nxt[run_idx] = tdfs_pkg::SLOT_RUNNING;
            owner_vld_nxt       = 1'b1;
          end
          owner_nxt = run_idx;
        end else if (fin_cnt_r < load_cnt_r) begin
          idle_cnt_nxt = (idle_cnt_r == TIME_MAX) ? idle_cnt_r : idle_cnt_r + TW'(1);
        end
        tick_nxt      = (tick_r == TIME_MAX) ? tick_r : tick_r + TW'(1);
        res_vld_nxt   = 1'b1;
        res_kind_nxt  = tdfs_pkg::KIND_SUMMARY;
        res_fslot_nxt = '0;
        res_ta_nxt    = '0;
        res_now_nxt   = now16;
        res_rslot_nxt = run_any ? FS'(run_idx) : '0;
        res_rvld_nxt  = run_any;
        res_busy_nxt  = tdfs_pkg::clamp16(32'(busy_cnt_nxt));
        res_idle_nxt  = tdfs_pkg::clamp16(32'(idle_cnt_nxt));
        res_done_nxt  = (fin_cnt_r == load_cnt_r);
        res_last_nxt  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SN; i++) begin
        status_r[i] <= tdfs_pkg::SLOT_EMPTY;
      end
      tick_r      <= '0;
      busy_cnt_r  <= '0;
      idle_cnt_r  <= '0;
      owner_vld_r <= 1'b0;
      fin_cnt_r   <= '0;
      load_cnt_r  <= '0;
      res_vld_r   <= 1'b0;
    end else begin
      status_r    <= status_nxt;
      tick_r      <= tick_nxt;
      busy_cnt_r  <= busy_cnt_nxt;
      idle_cnt_r  <= idle_cnt_nxt;
      owner_vld_r <= owner_vld_nxt;
      fin_cnt_r   <= fin_cnt_nxt;
      load_cnt_r  <= load_cnt_nxt;
      res_vld_r   <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cpu_left_r  <= cpu_left_nxt;
    io_left_r   <= io_left_nxt;
    arrival_r   <= arrival_nxt;
    owner_r     <= owner_nxt;
    cap_slot_r  <= cap_slot_nxt;
    cap_cpu_r   <= cap_cpu_nxt;
    cap_io_r    <= cap_io_nxt;
    cap_arr_r   <= cap_arr_nxt;
    res_kind_r  <= res_kind_nxt;
    res_fslot_r <= res_fslot_nxt;
    res_ta_r    <= res_ta_nxt;
    res_now_r   <= res_now_nxt;
    res_rslot_r <= res_rslot_nxt;
    res_rvld_r  <= res_rvld_nxt;
    res_busy_r  <= res_busy_nxt;
    res_idle_r  <= res_idle_nxt;
    res_done_r  <= res_done_nxt;
    res_last_r  <= res_last_nxt;
  end

  assign out_valid         = res_vld_r;
  assign out_kind          = res_kind_r;
  assign out_finished_slot = res_fslot_r;
  assign out_turnaround    = res_ta_r;
  assign out_current_time  = res_now_r;
  assign out_running_slot  = res_rslot_r;
  assign out_running_valid = res_rvld_r;
  assign out_busy_ticks    = res_busy_r;
  assign out_idle_ticks    = res_idle_r;
  assign out_all_done      = res_done_r;
  assign out_last          = res_last_r;

endmodule

// File: rtl/tick_driven_fcfs_process_scheduler_core.sv
// ----------------------------------------------------------------------------
// Tick driven FCFS process scheduler core
// Process-slot table with first-come-first-served CPU dispatch and I/O
// countdown, advanced one time unit per tick transaction.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake               Payload
//   -------   ---------------------   --------------------------------------
//   input     start / busy            in_op, in_slot, in_cpu_burst,
//                                     in_io_burst, in_arrival_time
//   result    out_valid (one cycle)   out_kind ... out_last
//
// A transaction is taken at a rising edge with start high and busy low.
// A load has a capture step, then the table write; its
// acknowledge is on the result ports in the cycle after, when busy is
// already low again. A tick has a capture step, one scan step per slot
// and a summary step; the scan visits the slots one per cycle, which
// sets the tick length.
// Reset is synchronous and active low; it empties every slot and clears
// the time, counters and CPU owner. Results cannot be stalled.
//
// The core splits into a controller, which sequences the steps of each
// transaction, and a datapath, which holds the slot table and the result
// register. They talk only through the command struct.
//
// Tick order: every blocked slot counts its I/O down during its scan cycle
// and, when it reaches zero, finishes and presents a finish result with its
// turnaround (current time minus arrival, zero if arrival is later). In the
// summary cycle a free CPU goes to the lowest ready slot, the owner runs for
// one unit and blocks for I/O when its CPU work is used up, the busy or
// idle counter advances (idle only while loaded work is open) and the
// time advances. Timers saturate at their maximum. Loads with a zero
// burst, or into a slot still in use, are refused and acknowledged with
// a turnaround field of zero.
module tick_driven_fcfs_process_scheduler_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [2:0]  in_slot,
  input  logic [15:0] in_cpu_burst,
  input  logic [15:0] in_io_burst,
  input  logic [15:0] in_arrival_time,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_finished_slot,
  output logic [15:0] out_turnaround,
  output logic [15:0] out_current_time,
  output logic [2:0]  out_running_slot,
  output logic        out_running_valid,
  output logic [15:0] out_busy_ticks,
  output logic [15:0] out_idle_ticks,
  output logic        out_all_done,
  output logic        out_last
);

  // Step command from the controller to the datapath.
  tdfs_pkg::dp_cmd_t cmd;

  tdfs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .busy  (busy),
    .cmd   (cmd)
  );

  tdfs_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_op             (in_op),
    .in_slot           (in_slot),
    .in_cpu_burst      (in_cpu_burst),
    .in_io_burst       (in_io_burst),
    .in_arrival_time   (in_arrival_time),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_finished_slot (out_finished_slot),
    .out_turnaround    (out_turnaround),
    .out_current_time  (out_current_time),
    .out_running_slot  (out_running_slot),
    .out_running_valid (out_running_valid),
    .out_busy_ticks    (out_busy_ticks),
    .out_idle_ticks    (out_idle_ticks),
    .out_all_done      (out_all_done),
    .out_last          (out_last)
  );

endmodule

// File: rtl/tdfs_checker.sv
// ----------------------------------------------------------------------------
// Scheduler port checker
// Watches the ports of the scheduler core for sequencing errors.
// ----------------------------------------------------------------------------
`include "tick_driven_fcfs_process_scheduler_core_assert.svh"

module tdfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_op,
  input logic        out_valid,
  input logic [1:0]  out_kind,
  input logic        out_running_valid,
  input logic        out_last
);

  // An accepted load is acknowledged after its load step, through the result register.
  `TDFS_ASSERT_DLY2(a_load_ack, start && !busy && !in_op, out_valid && out_kind == tdfs_pkg::KIND_ACK && out_last, "load transaction not acknowledged")

  // Any accepted transaction keeps the core occupied in the next cycle.
  `TDFS_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "core not busy after accept")

  // Only finish results may leave a transaction open.
  `TDFS_ASSERT_SAME(a_open_is_finish, out_valid && !out_last, out_kind == tdfs_pkg::KIND_FINISH, "non-final result is not a finish")

  // A finish result never names a running slot.
  `TDFS_ASSERT_SAME(a_finish_no_run, out_valid && out_kind == tdfs_pkg::KIND_FINISH, !out_running_valid && !out_last, "finish result marks a running slot or ends the transaction")

  // While the core is free, any result showing must close its transaction.
  `TDFS_ASSERT_SAME(a_idle_closes, out_valid && !busy, out_last, "open transaction while core is free")

endmodule

bind tick_driven_fcfs_process_scheduler_core tdfs_checker u_tdfs_checker (.*);

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scheduler core testbench
// Drives load and tick transactions into the FCFS scheduler core and checks
// every finish, summary and acknowledge result against a cycle-free model of
// the slot table kept inside the bench, or against a result typed by hand.
// ----------------------------------------------------------------------------
module tb;

  // Operation codes of the input channel.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Random transactions after the directed table.
  localparam int FRESH_ITEMS   = 100;
  // Covers a whole tick (capture, scan of every slot, summary) with margin.
  localparam int SETTLE_CYCLES = 30;
  localparam int MAX_SHOWN     = 10;

  // One input transaction.
  typedef struct packed {
    logic        op;
    logic [2:0]  slot;
    logic [15:0] cpu;
    logic [15:0] io;
    logic [15:0] arrival;
  } job_cmd_t;

  // One result as it appears on the out_ ports.
  typedef struct packed {
    tdfs_pkg::res_kind_t kind;
    logic [2:0]          fslot;
    logic [15:0]         turnaround;
    logic [15:0]         now;
    logic [2:0]          run_slot;
    logic                run_valid;
    logic [15:0]         busy_ticks;
    logic [15:0]         idle_ticks;
    logic                all_done;
    logic                last;
  } report_t;

  // A row of the directed table: the transaction and, where it is obvious,
  // the result typed in by hand.
  typedef struct packed {
    job_cmd_t cmd;
    logic     typed;
    report_t  rep;
  } directed_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_op;
  logic [2:0]  in_slot;
  logic [15:0] in_cpu_burst;
  logic [15:0] in_io_burst;
  logic [15:0] in_arrival_time;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [2:0]  out_finished_slot;
  logic [15:0] out_turnaround;
  logic [15:0] out_current_time;
  logic [2:0]  out_running_slot;
  logic        out_running_valid;
  logic [15:0] out_busy_ticks;
  logic [15:0] out_idle_ticks;
  logic        out_all_done;
  logic        out_last;

  tick_driven_fcfs_process_scheduler_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_slot           (in_slot),
    .in_cpu_burst      (in_cpu_burst),
    .in_io_burst       (in_io_burst),
    .in_arrival_time   (in_arrival_time),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_finished_slot (out_finished_slot),
    .out_turnaround    (out_turnaround),
    .out_current_time  (out_current_time),
    .out_running_slot  (out_running_slot),
    .out_running_valid (out_running_valid),
    .out_busy_ticks    (out_busy_ticks),
    .out_idle_ticks    (out_idle_ticks),
    .out_all_done      (out_all_done),
    .out_last          (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Scheduler model. This mirrors the slot table of the core: every slot's
  // status and remaining bursts, the time, the CPU owner and the tallies.
  // --------------------------------------------------------------------------
  tdfs_pkg::slot_state_t slot_st [8];
  logic [15:0] cpu_rem   [8];
  logic [15:0] io_rem    [8];
  logic [15:0] arr_time  [8];
  logic [15:0] clock_now;
  logic [15:0] busy_tally;
  logic [15:0] idle_tally;
  logic        owner_on;
  logic [2:0]  owner_idx;
  int          done_cnt;
  int          live_cnt;

  // Results still owed by the core, oldest first.
  report_t     owed_reports[$];
  int          mismatch_count;
  int          items_sent;
  bit          no_gaps;

  // Counters and time stop at their maximum instead of wrapping.
  function automatic logic [15:0] sat_up(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // A result as the model would emit it now; the tallies and the all-done
  // flag are taken from the model state at the moment of the call.
  function automatic report_t report_of(input tdfs_pkg::res_kind_t kind,
                                        input logic [2:0] fslot,
                                        input logic [15:0] ta, input logic [2:0] rslot,
                                        input logic rvalid, input logic last);
    report_t r;
    r.kind       = kind;
    r.fslot      = fslot;
    r.turnaround = ta;
    r.now        = clock_now;
    r.run_slot   = rslot;
    r.run_valid  = rvalid;
    r.busy_ticks = busy_tally;
    r.idle_ticks = idle_tally;
    r.all_done   = (done_cnt == live_cnt);
    r.last       = last;
    return r;
  endfunction

  function automatic bit slot_free(input int s);
    return (slot_st[s] == tdfs_pkg::SLOT_EMPTY) || (slot_st[s] == tdfs_pkg::SLOT_FINISHED);
  endfunction

  // Applies one accepted transaction to the model and returns the results
  // that it causes, in the order the core must present them.
  task automatic advance_schedule(input job_cmd_t c, ref report_t outs[$]);
    bit          ok;
    bit          ran;
    logic [2:0]  who;
    logic [15:0] ta;
    outs.delete();
    if (c.op == OP_LOAD) begin
      // A zero burst or an occupied slot refuses the load. A finished slot
      // may be reused and then no longer counts as finished.
      ok = (c.cpu != 16'd0) && (c.io != 16'd0) && slot_free(int'(c.slot));
      if (ok) begin
        if (slot_st[c.slot] == tdfs_pkg::SLOT_EMPTY) begin
          live_cnt++;
        end else begin
          done_cnt--;
        end
        slot_st[c.slot]  = tdfs_pkg::SLOT_READY;
        cpu_rem[c.slot]  = c.cpu;
        io_rem[c.slot]   = c.io;
        arr_time[c.slot] = c.arrival;
      end
      outs.push_back(report_of(tdfs_pkg::KIND_ACK, c.slot, {15'd0, ok},
                               owner_on ? owner_idx : 3'd0, owner_on, 1'b1));
    end else begin
      // I/O countdown first; each slot reaching zero finishes right away.
      for (int i = 0; i < 8; i++) begin
        if (slot_st[i] == tdfs_pkg::SLOT_BLOCKED) begin
          if (io_rem[i] != 16'd0) begin
            io_rem[i]--;
          end
          if (io_rem[i] == 16'd0) begin
            // An arrival later than the finish gives a turnaround of zero.
            ta = (clock_now >= arr_time[i]) ? clock_now - arr_time[i] : 16'd0;
            slot_st[i] = tdfs_pkg::SLOT_FINISHED;
            done_cnt++;
            outs.push_back(report_of(tdfs_pkg::KIND_FINISH, i[2:0], ta, 3'd0,
                                     1'b0, 1'b0));
          end
        end
      end
      // A free CPU goes to the lowest ready slot, regardless of arrival.
      if (!owner_on) begin
        for (int i = 0; i < 8; i++) begin
          if (!owner_on && slot_st[i] == tdfs_pkg::SLOT_READY) begin
            slot_st[i] = tdfs_pkg::SLOT_RUNNING;
            owner_idx  = i[2:0];
            owner_on   = 1'b1;
          end
        end
      end
      ran = owner_on;
      who = owner_on ? owner_idx : 3'd0;
      if (ran) begin
        busy_tally = sat_up(busy_tally);
        if (cpu_rem[owner_idx] != 16'd0) begin
          cpu_rem[owner_idx]--;
        end
        if (cpu_rem[owner_idx] == 16'd0) begin
          slot_st[owner_idx] = tdfs_pkg::SLOT_BLOCKED;
          owner_on = 1'b0;
        end
      end else if (done_cnt < live_cnt) begin
        // Idle ticks only count while some loaded work is still open.
        idle_tally = sat_up(idle_tally);
      end
      outs.push_back(report_of(tdfs_pkg::KIND_SUMMARY, 3'd0, 16'd0, who, ran, 1'b1));
      clock_now = sat_up(clock_now);
    end
  endtask

  // --------------------------------------------------------------------------
  // Transaction driver. Each call may idle first, then holds start high until
  // the core takes the transaction. The model runs at the accepting edge.
  // --------------------------------------------------------------------------
  task automatic issue(input job_cmd_t c, input logic typed = 1'b0,
                       input report_t typed_rep = '0);
    report_t outs[$];
    if (!no_gaps) begin
      while ($urandom_range(99) < 26) begin
        // Idle cycle; the payload wanders so that it is never trusted
        // while start is low.
        start           <= 1'b0;
        in_slot         <= 3'($urandom);
        in_cpu_burst    <= 16'($urandom);
        @(posedge clk);
      end
    end
    start           <= 1'b1;
    in_op           <= c.op;
    in_slot         <= c.slot;
    in_cpu_burst    <= c.cpu;
    in_io_burst     <= c.io;
    in_arrival_time <= c.arrival;
    do @(posedge clk); while (busy);
    advance_schedule(c, outs);
    if (typed) begin
      outs.delete();
      outs.push_back(typed_rep);
    end
    foreach (outs[k]) begin
      owed_reports.push_back(outs[k]);
    end
    items_sent++;
    no_gaps = (items_sent >= 70) && (items_sent < 110);
  endtask

  function automatic job_cmd_t tk();
    job_cmd_t c;
    c = '0;
    c.op = OP_TICK;
    c.slot = 3'($urandom);
    c.cpu = 16'($urandom);
    c.io = 16'($urandom);
    c.arrival = 16'($urandom);
    return c;
  endfunction

  function automatic job_cmd_t ld(input logic [2:0] s, input logic [15:0] cb,
                                  input logic [15:0] ib, input logic [15:0] at);
    return '{op: OP_LOAD, slot: s, cpu: cb, io: ib, arrival: at};
  endfunction

  // A hand-written single result; all of these close their transaction.
  function automatic report_t rep(input tdfs_pkg::res_kind_t kind, input logic [2:0] fs,
                                  input logic [15:0] ta, input logic [15:0] ct,
                                  input logic [2:0] rs, input logic rv,
                                  input logic [15:0] bt, input logic [15:0] it,
                                  input logic ad);
    return '{kind: kind, fslot: fs, turnaround: ta, now: ct, run_slot: rs,
             run_valid: rv, busy_ticks: bt, idle_ticks: it, all_done: ad,
             last: 1'b1};
  endfunction

  // A load that is either refused (zero or wide bursts into a busy slot) or,
  // if it would be taken, trimmed to short bursts so the table keeps moving.
  function automatic job_cmd_t stray_load();
    job_cmd_t c;
    c = ld(3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    if ($urandom_range(3) == 0) c.cpu = 16'd0;
    if ($urandom_range(3) == 0) c.io = 16'd0;
    if (c.cpu != 16'd0 && c.io != 16'd0 && slot_free(int'(c.slot))) begin
      c.cpu = (c.cpu % 16'd4) + 16'd1;
      c.io  = (c.io % 16'd6) + 16'd1;
    end
    return c;
  endfunction

  // Keeps ticking, with some stray loads mixed in, until every loaded process has finished, with a cap.
  task automatic settle_ticks(input int cap);
    int n;
    n = 0;
    while (done_cnt != live_cnt && n < cap) begin
      if ($urandom_range(99) < 12) begin
        issue(stray_load());
      end else begin
        issue(tk());
      end
      n++;
    end
  endtask

  // A well-formed batch: fill some free slots with short jobs, then run the
  // table until they are all through.
  task automatic run_batch();
    logic [15:0] at;
    for (int s = 0; s < 8; s++) begin
      if (slot_free(s) && $urandom_range(1) == 1) begin
        at = clock_now - 16'($urandom_range(0, 12));
        if ($urandom_range(7) == 0) at = 16'($urandom);
        issue(ld(s[2:0], 16'($urandom_range(1, 3)), 16'($urandom_range(1, 6)), at));
      end
    end
    settle_ticks(80);
    repeat ($urandom_range(0, 2)) issue(tk());
  endtask

  function automatic string show(input report_t r);
    return {$sformatf("kind=%0d slot=%0d ta=%0d now=%0d run=%0d/%0b ",
                      r.kind, r.fslot, r.turnaround, r.now, r.run_slot, r.run_valid),
            $sformatf("busy=%0d idle=%0d done=%0b last=%0b",
                      r.busy_ticks, r.idle_ticks, r.all_done, r.last)};
  endfunction

  // --------------------------------------------------------------------------
  // Result checker. A result is on the ports for exactly one cycle and is
  // taken at the edge that ends it; it must match the oldest owed result.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    report_t seen;
    report_t want;
    if (rst_n && out_valid) begin
      seen.kind       = tdfs_pkg::res_kind_t'(out_kind);
      seen.fslot      = out_finished_slot;
      seen.turnaround = out_turnaround;
      seen.now        = out_current_time;
      seen.run_slot   = out_running_slot;
      seen.run_valid  = out_running_valid;
      seen.busy_ticks = out_busy_ticks;
      seen.idle_ticks = out_idle_ticks;
      seen.all_done   = out_all_done;
      seen.last       = out_last;
      if (owed_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN) begin
          $display("unexpected result at %0t: %s", $realtime, show(seen));
        end
      end else begin
        want = owed_reports.pop_front();
        if (seen !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN) begin
            $display("mismatch at %0t\n  expected %s\n  actual   %s",
                     $realtime, show(want), show(seen));
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin
    directed_row_t directed[];
    int            free_slot;

    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_op           <= OP_LOAD;
    in_slot         <= '0;
    in_cpu_burst    <= '0;
    in_io_burst     <= '0;
    in_arrival_time <= '0;

    for (int i = 0; i < 8; i++) begin
      slot_st[i]  = tdfs_pkg::SLOT_EMPTY;
      cpu_rem[i]  = '0;
      io_rem[i]   = '0;
      arr_time[i] = '0;
    end
    clock_now      = '0;
    busy_tally     = '0;
    idle_tally     = '0;
    owner_on       = 1'b0;
    owner_idx      = '0;
    done_cnt       = 0;
    live_cnt       = 0;
    mismatch_count = 0;
    items_sent     = 0;
    no_gaps        = 1'b0;

    // Directed part. A tick on the empty table, refused loads for each zero
    // burst and for a slot in use, an arrival later than the finish, a spell
    // of idle ticks while work is still blocked on I/O, idle ticks with
    // nothing left, and reuse of a finished slot.
    directed = '{
      '{tk(), 1'b1,
        rep(tdfs_pkg::KIND_SUMMARY, 3'd0, 16'd0, 16'd0, 3'd0, 1'b0, 16'd0, 16'd0, 1'b1)},
      '{ld(3'd0, 16'd0, 16'd5, 16'd0), 1'b1,
        rep(tdfs_pkg::KIND_ACK, 3'd0, 16'd0, 16'd1, 3'd0, 1'b0, 16'd0, 16'd0, 1'b1)},
      '{ld(3'd1, 16'd3, 16'd0, 16'd0), 1'b1,
        rep(tdfs_pkg::KIND_ACK, 3'd1, 16'd0, 16'd1, 3'd0, 1'b0, 16'd0, 16'd0, 1'b1)},
      '{ld(3'd7, 16'd1, 16'd1, 16'd0), 1'b1,
        rep(tdfs_pkg::KIND_ACK, 3'd7, 16'd1, 16'd1, 3'd0, 1'b0, 16'd0, 16'd0, 1'b0)},
      '{ld(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1,
        rep(tdfs_pkg::KIND_ACK, 3'd7, 16'd0, 16'd1, 3'd0, 1'b0, 16'd0, 16'd0, 1'b0)},
      '{ld(3'd2, 16'd2, 16'd1, 16'hFFFF), 1'b1,
        rep(tdfs_pkg::KIND_ACK, 3'd2, 16'd1, 16'd1, 3'd0, 1'b0, 16'd0, 16'd0, 1'b0)},
      '{ld(3'd3, 16'd1, 16'd4, 16'd1), 1'b1,
        rep(tdfs_pkg::KIND_ACK, 3'd3, 16'd1, 16'd1, 3'd0, 1'b0, 16'd0, 16'd0, 1'b0)},
      '{tk(), 1'b0, '0}, '{tk(), 1'b0, '0}, '{tk(), 1'b0, '0},
      '{tk(), 1'b0, '0}, '{tk(), 1'b0, '0}, '{tk(), 1'b0, '0},
      '{tk(), 1'b0, '0}, '{tk(), 1'b0, '0}, '{tk(), 1'b0, '0},
      '{ld(3'd7, 16'd1, 16'd1, 16'd3), 1'b0, '0},
      '{ld(3'd5, 16'd3, 16'd2, 16'h8000), 1'b0, '0},
      '{tk(), 1'b0, '0}, '{tk(), 1'b0, '0}, '{tk(), 1'b0, '0},
      '{tk(), 1'b0, '0}, '{tk(), 1'b0, '0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[r]) begin
      issue(directed[r].cmd, directed[r].typed, directed[r].rep);
    end

    // Hold the input off until the core has delivered every owed result.
    start <= 1'b0;
    do @(posedge clk); while (owed_reports.size() != 0);

    // Random part: mostly well-formed batches, with bursts of stray traffic.
    while (items_sent < directed.size() + FRESH_ITEMS) begin
      if ($urandom_range(99) < 70) begin
        run_batch();
      end else begin
        repeat ($urandom_range(2, 6)) begin
          if ($urandom_range(1) == 1) begin
            issue(tk());
          end else begin
            issue(stray_load());
          end
        end
      end
    end

    // Close out: drain the table, then run one job with the widest bursts
    // for a few ticks so the top bits are taken by a live slot too.
    settle_ticks(200);
    free_slot = -1;
    for (int s = 7; s >= 0; s--) begin
      if (slot_free(s)) free_slot = s;
    end
    if (free_slot >= 0) begin
      issue(ld(free_slot[2:0], 16'hFFFF, 16'hFFFF, 16'($urandom)));
      repeat (4) issue(tk());
    end

    start <= 1'b0;
    while (owed_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && owed_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond any correct run.
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
